// ===== hdl/tsukamoto_fuzzy_inference_2x3_unit_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef TSUKAMOTO_FUZZY_INFERENCE_2X3_UNIT_MACROS_SVH
`define TSUKAMOTO_FUZZY_INFERENCE_2X3_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TFI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TFI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFI_ASSERT_IMP(lbl, ante, cons, msg)
`define TFI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/tfi_pkg.sv =====
package tfi_pkg;

    localparam int unsigned VAL_W     = 16;
    localparam int unsigned MEMB_W    = 16;
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MEMB_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMT_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMT_MID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMT_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MID    = 3'd7;

    localparam logic [VAL_W-1:0] CFG_RESET [NUM_CFG] = '{
        16'd16384, 16'd32768, 16'd49152, 16'd16384,
        16'd32768, 16'd49152, 16'd0, 16'd32768
    };

    localparam int unsigned OUT_BREAK_HIGH_DEF = 65535;

    // Rule slots: 0..8 in row order of (first input set, second input set).
    localparam int unsigned NUM_RULES = 9;
    // Sample lanes: four small, two medium rising, two medium falling, three large.
    localparam int unsigned NUM_LANES = 11;
    localparam int unsigned LANE_SRC [NUM_LANES] = '{0, 1, 3, 6, 2, 4, 2, 4, 5, 7, 8};
    localparam logic [NUM_LANES-1:0] LANE_RISE  = 11'b111_0011_0000;
    localparam logic [NUM_LANES-1:0] LANE_UPPER = 11'b111_1100_0000;

    localparam int unsigned DEN_W  = 19;
    localparam int unsigned SAMP_W = 31;
    localparam int unsigned TERM_W = 47;
    localparam int unsigned PSUM_W = 49;
    localparam int unsigned NUM_W  = 51;
    localparam int unsigned QUO_W  = 24;

    typedef struct packed {
        logic [VAL_W-1:0] count_value;
        logic [VAL_W-1:0] amount_value;
    } t_in;

    typedef struct packed {
        logic [QUO_W-1:0] crisp_result;
        logic             weight_error;
    } t_out;

    typedef struct packed {
        logic [MEMB_W-1:0] low;
        logic [MEMB_W-1:0] mid;
        logic [MEMB_W-1:0] high;
    } t_memb;

endpackage

// ===== hdl/tsukamoto_fuzzy_inference_2x3_unit.sv =====
// Path of a word: fuzzifiers, rule strengths, lane samples, terms, partial sums, output divider.
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// The depth is set by the 15-bit membership dividers and the 24-bit output divider.
// Reset is synchronous and active low: it clears the valid bits and loads the
// breakpoint registers with their default values.
`include "tsukamoto_fuzzy_inference_2x3_unit_macros.svh"

module tsukamoto_fuzzy_inference_2x3_unit
    import tfi_pkg::*;
#(
    parameter int unsigned OUT_BREAK_HIGH = OUT_BREAK_HIGH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata
);

    localparam int unsigned LAT     = 17;
    localparam int unsigned DSTAGES = 6;
    localparam int unsigned DPER    = 4;

    logic [VAL_W-1:0] r_cfg [NUM_CFG];
    logic [LAT-1:0]   r_vld;
    logic             w_en;

    t_memb w_mc;
    t_memb w_ma;

    logic [VAL_W-1:0] w_b0;
    logic [VAL_W-1:0] w_b1;
    logic [VAL_W-1:0] w_b2;

    logic [MEMB_W-1:0] r_w7    [NUM_RULES];
    logic [SAMP_W-1:0] r_samp8 [NUM_LANES];
    logic [MEMB_W-1:0] r_lw8   [NUM_LANES];
    logic [TERM_W-1:0] r_term9 [NUM_LANES];
    logic [PSUM_W-1:0] r_ps10  [3];
    logic [DEN_W-1:0]  r_den8;
    logic [DEN_W-1:0]  r_den9;
    logic [DEN_W-1:0]  r_den10;
    logic [DEN_W-1:0]  n_den8;
    logic [NUM_W-1:0]  v_num;

    logic [DEN_W-1:0] r_drem [0:DSTAGES];
    logic [QUO_W-1:0] r_dlow [0:DSTAGES];
    logic [QUO_W-1:0] r_dq   [0:DSTAGES];
    logic [DEN_W-1:0] r_dden [0:DSTAGES];
    logic             r_derr [0:DSTAGES];

    function automatic logic [MEMB_W-1:0] min16(input logic [MEMB_W-1:0] a,
                                                input logic [MEMB_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    assign w_b0 = r_cfg[CFG_OUT_LOW];
    assign w_b1 = r_cfg[CFG_OUT_MID];
    assign w_b2 = VAL_W'(OUT_BREAK_HIGH);

    tfi_fuzzify u_fz_count (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (i_in_data.count_value),
        .i_lo   (r_cfg[CFG_COUNT_LOW]),
        .i_md   (r_cfg[CFG_COUNT_MID]),
        .i_hi   (r_cfg[CFG_COUNT_HIGH]),
        .o_memb (w_mc)
    );

    tfi_fuzzify u_fz_amount (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (i_in_data.amount_value),
        .i_lo   (r_cfg[CFG_AMT_LOW]),
        .i_md   (r_cfg[CFG_AMT_MID]),
        .i_hi   (r_cfg[CFG_AMT_HIGH]),
        .o_memb (w_ma)
    );

    // Rule strengths.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w7[0] <= min16(w_mc.low,  w_ma.low);
            r_w7[1] <= min16(w_mc.low,  w_ma.mid);
            r_w7[2] <= min16(w_mc.low,  w_ma.high);
            r_w7[3] <= min16(w_mc.mid,  w_ma.low);
            r_w7[4] <= min16(w_mc.mid,  w_ma.mid);
            r_w7[5] <= min16(w_mc.mid,  w_ma.high);
            r_w7[6] <= min16(w_mc.high, w_ma.low);
            r_w7[7] <= min16(w_mc.high, w_ma.mid);
            r_w7[8] <= min16(w_mc.high, w_ma.high);
        end
    end

    // Medium strengths sit in two lanes each, so they count twice here.
    always_comb begin
        n_den8 = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_den8 = n_den8 + DEN_W'(r_w7[LANE_SRC[l]]);
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [MEMB_W-1:0]    v_w;
        logic [VAL_W-1:0]     v_bot;
        logic [VAL_W-1:0]     v_top;
        logic signed [VAL_W:0]   v_diff;
        logic signed [33:0]   v_prod;
        logic signed [34:0]   v_base;
        logic signed [34:0]   v_samp;

        assign v_w    = r_w7[LANE_SRC[l]];
        assign v_bot  = LANE_UPPER[l] ? w_b1 : w_b0;
        assign v_top  = LANE_UPPER[l] ? w_b2 : w_b1;
        assign v_diff = $signed({1'b0, v_top}) - $signed({1'b0, v_bot});
        assign v_prod = $signed({1'b0, v_w}) * v_diff;
        assign v_base = $signed({4'd0, (LANE_RISE[l] ? v_bot : v_top), 15'd0});
        assign v_samp = LANE_RISE[l] ? (v_base + 35'(v_prod)) : (v_base - 35'(v_prod));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_samp8[l] <= v_samp[SAMP_W-1:0];
                r_lw8[l]   <= v_w;
                r_term9[l] <= TERM_W'(r_lw8[l]) * TERM_W'(r_samp8[l]);
            end
        end
    end

    assign v_num = NUM_W'(r_ps10[0]) + NUM_W'(r_ps10[1]) + NUM_W'(r_ps10[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den8    <= n_den8;
            r_den9    <= r_den8;
            r_den10   <= r_den9;
            r_ps10[0] <= PSUM_W'(r_term9[0]) + PSUM_W'(r_term9[1])
                       + PSUM_W'(r_term9[2]) + PSUM_W'(r_term9[3]);
            r_ps10[1] <= PSUM_W'(r_term9[4]) + PSUM_W'(r_term9[5])
                       + PSUM_W'(r_term9[6]) + PSUM_W'(r_term9[7]);
            r_ps10[2] <= PSUM_W'(r_term9[8]) + PSUM_W'(r_term9[9])
                       + PSUM_W'(r_term9[10]);
            // Dropping the low 7 bits first gives the same quotient as dividing by den * 128.
            r_drem[0] <= v_num[49:31];
            r_dlow[0] <= v_num[30:7];
            r_dq[0]   <= '0;
            r_dden[0] <= r_den10;
            r_derr[0] <= (r_den10 == '0);
        end
    end

    for (genvar s = 1; s <= DSTAGES; s++) begin : g_odiv
        logic [DEN_W-1:0] n_rem;
        logic [QUO_W-1:0] n_low;
        logic [QUO_W-1:0] n_q;
        logic [DEN_W:0]   v_t;

        always_comb begin
            n_rem = r_drem[s-1];
            n_low = r_dlow[s-1];
            n_q   = r_dq[s-1];
            v_t   = '0;
            for (int j = 0; j < DPER; j++) begin
                v_t   = {n_rem, n_low[QUO_W-1]};
                n_low = {n_low[QUO_W-2:0], 1'b0};
                if (v_t >= {1'b0, r_dden[s-1]}) begin
                    n_rem = DEN_W'(v_t - {1'b0, r_dden[s-1]});
                    n_q   = {n_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = v_t[DEN_W-1:0];
                    n_q   = {n_q[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_drem[s] <= n_rem;
                r_dlow[s] <= n_low;
                r_dq[s]   <= n_q;
                r_dden[s] <= r_dden[s-1];
                r_derr[s] <= r_derr[s-1];
            end
        end
    end

    assign o_out_data.crisp_result = r_derr[DSTAGES] ? '0 : r_dq[DSTAGES];
    assign o_out_data.weight_error = r_derr[DSTAGES];

    `TFI_ASSERT_NXT(a_accept_enters, i_in_valid && o_in_ready, r_vld[0], "accepted word lost at entry")
    `TFI_ASSERT_NXT(a_stall_freezes, !w_en, $stable(r_vld), "pipeline moved during a stall")
    `TFI_ASSERT_IMP(a_den_nonzero, r_vld[10], r_dden[0] != '0, "rule weight sum is zero")

endmodule

// ===== hdl/tfi_fuzzify.sv =====
module tfi_fuzzify
    import tfi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [VAL_W-1:0] i_x,
    input  logic [VAL_W-1:0] i_lo,
    input  logic [VAL_W-1:0] i_md,
    input  logic [VAL_W-1:0] i_hi,
    output t_memb            o_memb
);

    localparam logic [2:0] CLS_LOW  = 3'd0;
    localparam logic [2:0] CLS_RISE = 3'd1;
    localparam logic [2:0] CLS_MID  = 3'd2;
    localparam logic [2:0] CLS_FALL = 3'd3;
    localparam logic [2:0] CLS_HIGH = 3'd4;

    localparam int unsigned STEPS  = 15;
    localparam int unsigned STAGES = 4;
    localparam int unsigned PER    = 4;

    logic [2:0]       r_cls [0:STAGES];
    logic [VAL_W-1:0] r_rem [0:STAGES];
    logic [VAL_W-1:0] r_d   [0:STAGES];
    logic [STEPS-1:0] r_q   [0:STAGES];

    logic [2:0]       n_cls;
    logic [VAL_W-1:0] n_a;
    logic [VAL_W-1:0] n_d;

    t_memb            n_memb;
    t_memb            r_memb;
    logic [MEMB_W-1:0] v_comp;

    always_comb begin
        n_cls = CLS_HIGH;
        n_a   = '0;
        n_d   = 16'd1;
        priority if (i_x <= i_lo) begin
            n_cls = CLS_LOW;
        end else if (i_x < i_md) begin
            n_cls = CLS_RISE;
            n_a   = i_x - i_lo;
            n_d   = i_md - i_lo;
        end else if (i_x == i_md) begin
            n_cls = CLS_MID;
        end else if (i_x < i_hi) begin
            n_cls = CLS_FALL;
            n_a   = i_x - i_md;
            n_d   = i_hi - i_md;
        end else begin
            n_cls = CLS_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cls[0] <= n_cls;
            r_rem[0] <= n_a;
            r_d[0]   <= n_d;
            r_q[0]   <= '0;
        end
    end

    // Restoring division of a * 2^15 by d; a < d keeps the quotient in 15 bits.
    for (genvar s = 1; s <= STAGES; s++) begin : g_div
        logic [VAL_W-1:0] n_rem;
        logic [STEPS-1:0] n_q;
        logic [VAL_W:0]   v_t;

        always_comb begin
            n_rem = r_rem[s-1];
            n_q   = r_q[s-1];
            v_t   = '0;
            for (int j = 0; j < PER; j++) begin
                if ((s - 1) * PER + j < STEPS) begin
                    v_t = {n_rem, 1'b0};
                    if (v_t >= {1'b0, r_d[s-1]}) begin
                        n_rem = VAL_W'(v_t - {1'b0, r_d[s-1]});
                        n_q   = {n_q[STEPS-2:0], 1'b1};
                    end else begin
                        n_rem = v_t[VAL_W-1:0];
                        n_q   = {n_q[STEPS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cls[s] <= r_cls[s-1];
                r_d[s]   <= r_d[s-1];
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
            end
        end
    end

    // The complementary membership is 1.0 - q, one less when the division left a remainder.
    assign v_comp = ONE_Q15 - {1'b0, r_q[STAGES]} - {15'd0, (r_rem[STAGES] != '0)};

    always_comb begin
        n_memb = '0;
        unique case (r_cls[STAGES])
            CLS_LOW: begin
                n_memb.low = ONE_Q15;
            end
            CLS_RISE: begin
                n_memb.low = v_comp;
                n_memb.mid = {1'b0, r_q[STAGES]};
            end
            CLS_MID: begin
                n_memb.mid = ONE_Q15;
            end
            CLS_FALL: begin
                n_memb.mid  = v_comp;
                n_memb.high = {1'b0, r_q[STAGES]};
            end
            default: begin
                n_memb.high = ONE_Q15;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_memb <= n_memb;
        end
    end

    assign o_memb = r_memb;

endmodule

// ===== tb/tb_tsukamoto_fuzzy_inference_2x3_unit.sv =====
module tb_tsukamoto_fuzzy_inference_2x3_unit;
    import tfi_pkg::*;

    localparam int unsigned PIPE_DEPTH = 17;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned WORDS_PER_PHASE = 150;
    localparam int unsigned NUM_PHASES = 8;

    class fuzzy_scoreboard;
        logic [VAL_W-1:0] brk [NUM_CFG];
        t_out pending [$];
        int errors;

        function new();
            foreach (brk[i]) brk[i] = CFG_RESET[i];
            errors = 0;
        endfunction

        // Low shoulder, middle triangle, high shoulder in Q1.15.
        function automatic void grade(longint x, longint lo, longint md, longint hi,
                                      output longint m [3]);
            longint d;
            m[0] = 0; m[1] = 0; m[2] = 0;
            if (x <= lo) begin
                m[0] = 32768;
            end else if (x < md) begin
                d = md - lo;
                m[0] = ((md - x) * 32768) / d;
                m[1] = ((x - lo) * 32768) / d;
            end else if (x == md) begin
                m[1] = 32768;
            end else if (x < hi) begin
                d = hi - md;
                m[1] = ((hi - x) * 32768) / d;
                m[2] = ((x - md) * 32768) / d;
            end else begin
                m[2] = 32768;
            end
        endfunction

        function automatic t_out infer(t_in w);
            longint mc [3];
            longint ma [3];
            longint sm [4];
            longint me [2];
            longint lg [3];
            longint b0, b1, b2, num, den;
            t_out r;
            b0 = brk[CFG_OUT_LOW];
            b1 = brk[CFG_OUT_MID];
            b2 = OUT_BREAK_HIGH_DEF;
            grade(w.count_value, brk[CFG_COUNT_LOW], brk[CFG_COUNT_MID],
                  brk[CFG_COUNT_HIGH], mc);
            grade(w.amount_value, brk[CFG_AMT_LOW], brk[CFG_AMT_MID],
                  brk[CFG_AMT_HIGH], ma);
            sm[0] = mc[0] < ma[0] ? mc[0] : ma[0];
            sm[1] = mc[0] < ma[1] ? mc[0] : ma[1];
            me[0] = mc[0] < ma[2] ? mc[0] : ma[2];
            sm[2] = mc[1] < ma[0] ? mc[1] : ma[0];
            me[1] = mc[1] < ma[1] ? mc[1] : ma[1];
            lg[0] = mc[1] < ma[2] ? mc[1] : ma[2];
            sm[3] = mc[2] < ma[0] ? mc[2] : ma[0];
            lg[1] = mc[2] < ma[1] ? mc[2] : ma[1];
            lg[2] = mc[2] < ma[2] ? mc[2] : ma[2];
            num = 0;
            den = 0;
            foreach (sm[i]) begin
                num += sm[i] * (b1 * 32768 - sm[i] * (b1 - b0));
                den += sm[i];
            end
            // A medium rule yields a rising and a falling sample, so it weighs twice.
            foreach (me[i]) begin
                num += me[i] * (b0 * 32768 + me[i] * (b1 - b0));
                num += me[i] * (b2 * 32768 - me[i] * (b2 - b1));
                den += 2 * me[i];
            end
            foreach (lg[i]) begin
                num += lg[i] * (b1 * 32768 + lg[i] * (b2 - b1));
                den += lg[i];
            end
            if (den == 0) begin
                r.crisp_result = '0;
                r.weight_error = 1'b1;
            end else begin
                r.crisp_result = QUO_W'(num / (den * 128));
                r.weight_error = 1'b0;
            end
            return r;
        endfunction

        function void note_input(t_in w);
            pending.push_back(infer(w));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word crisp_result=%0d weight_error=%0b",
                         $time, got.crisp_result, got.weight_error);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.crisp_result !== want.crisp_result) begin
                $display("%0t: crisp_result expected %0d, actual %0d",
                         $time, want.crisp_result, got.crisp_result);
                errors++;
            end
            if (got.weight_error !== want.weight_error) begin
                $display("%0t: weight_error expected %0b, actual %0b",
                         $time, want.weight_error, got.weight_error);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [VAL_W-1:0]     i_cfg_wdata = '0;

    fuzzy_scoreboard sb = new();
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    tsukamoto_fuzzy_inference_2x3_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Leaves the caller at the edge where the word was taken.
    task automatic send_word(logic [VAL_W-1:0] cnt, logic [VAL_W-1:0] amt);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{count_value: cnt, amount_value: amt};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic load_breaks(logic [VAL_W-1:0] v [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(i);
            i_cfg_wdata <= v[i];
            @(posedge i_clk);
            sb.brk[i] = v[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Values cluster around a breakpoint to hit the boundaries often.
    function automatic logic [VAL_W-1:0] near(logic [VAL_W-1:0] b);
        int d;
        if ($urandom_range(1)) return VAL_W'($urandom);
        d = int'($urandom_range(8)) - 4;
        return VAL_W'(int'(b) + d);
    endfunction

    initial begin
        logic [VAL_W-1:0] setting [NUM_CFG];
        logic [VAL_W-1:0] lo, md, hi;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the extremes and around every input breakpoint.
        lo = CFG_RESET[CFG_COUNT_LOW];
        md = CFG_RESET[CFG_COUNT_MID];
        hi = CFG_RESET[CFG_COUNT_HIGH];
        send_word(16'd0, 16'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'd0, 16'hFFFF);
        send_word(16'hFFFF, 16'd0);
        send_word(16'hAAAA, 16'h5555);
        send_word(16'h5555, 16'hAAAA);
        send_word(lo, lo);
        send_word(lo + 16'd1, md - 16'd1);
        send_word(md, md);
        send_word(md + 16'd1, hi - 16'd1);
        send_word(hi, hi);
        send_word(hi - 16'd1, lo + 16'd1);
        send_word(md, 16'd20000);
        send_word(16'd40000, md);
        send_word(lo, hi);
        send_word(hi, lo);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
                default: begin send_gap_pct = 16; recv_stall_pct = 16; end
            endcase
            case (p)
                0: setting = CFG_RESET;
                1: foreach (setting[i]) setting[i] = 16'd0;
                2: foreach (setting[i]) setting[i] = 16'hFFFF;
                3: begin
                    setting = CFG_RESET;
                    setting[CFG_OUT_LOW] = 16'hFFFF;
                    setting[CFG_OUT_MID] = 16'd0;
                end
                4: begin
                    setting = '{16'd0, 16'd1, 16'd2, 16'd65533, 16'd65534, 16'd65535,
                                16'd65535, 16'd65535};
                end
                5: begin
                    // Ordered random breakpoints per input.
                    for (int k = 0; k < 6; k += 3) begin
                        lo = VAL_W'($urandom_range(30000));
                        md = lo + VAL_W'($urandom_range(1, 15000));
                        hi = md + VAL_W'($urandom_range(1, 20000));
                        setting[k] = lo;
                        setting[k + 1] = md;
                        setting[k + 2] = hi;
                    end
                    setting[CFG_OUT_LOW] = VAL_W'($urandom_range(30000));
                    setting[CFG_OUT_MID] = VAL_W'($urandom_range(30000, 65535));
                end
                default: foreach (setting[i]) setting[i] = VAL_W'($urandom);
            endcase
            load_breaks(setting);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(near(setting[$urandom_range(2)]),
                          near(setting[$urandom_range(3, 5)]));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
